// ===== hw/rtl/pipw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pipw_pkg
// Shared types and constants of the winding-number point-in-polygon block.
// ----------------------------------------------------------------------------
package pipw_pkg;

   localparam int COORD_W   = 32;   // signed Q16.16 coordinate
   localparam int SLOT_W    = 6;    // vertex slot field
   localparam int WIND_W    = 7;    // winding number field
   localparam int CFG_W     = 7;    // vertex_count register
   localparam int CNT_RESET = 4;    // vertex_count after reset
   localparam int WIND_MAX  = 63;
   localparam int WIND_MIN  = -64;

   // transaction kinds
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TEST = 1'b1;

   typedef struct packed {
      logic                      op;
      logic [SLOT_W-1:0]         slot;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } cmd_type;

   typedef struct packed {
      logic                     inside_res;
      logic signed [WIND_W-1:0] winding;
   } rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/point_in_polygon_winding.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_polygon_winding
// Winding-number point-in-polygon test over a loadable vertex table.
// Throughput: one load per cycle while the engine is idle; a test holds the
//   engine until its result is queued, walking one edge per cycle through the
//   single read port of the vertex memory (no edges with a count of zero).
// Reset: synchronous, clears both queues and the engine; vertex_count goes to
//   4, the vertex table is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
module point_in_polygon_winding
   import pipw_pkg::*;
#(
   parameter int MAX_VERTICES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_kind,
   input  logic [SLOT_W-1:0]         req_vertex_index,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic                      rsp_inside_res,
   output logic signed [WIND_W-1:0]  rsp_winding,
   input  logic                      csr_wr_en,
   input  logic [CFG_W-1:0]          csr_wr_data
);

   localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
   localparam int CFGX_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int CNT_RST = (CNT_RESET > MAX_VERTICES) ? MAX_VERTICES : CNT_RESET;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CFGX_W-1:0] cfg_ext;
   logic              cmd_valid;
   logic              cmd_pop;
   cmd_type           cmd;
   logic              eng_push;
   logic              eng_full;
   rsp_type           eng_rsp;
   rsp_type           out_rsp;

   // counts above the table size saturate
   assign cfg_ext  = CFGX_W'(csr_wr_data);
   assign count_in = (int'(csr_wr_data) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                        : cfg_ext[CNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(CNT_RST);
      end else if (csr_wr_en) begin
         count_ff <= count_in;
      end
   end

   pipw_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_kind         (req_kind),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .cmd_valid        (cmd_valid),
      .cmd_pop          (cmd_pop),
      .cmd              (cmd)
   );

   pipw_engine #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .vertex_count (count_ff),
      .cmd_valid    (cmd_valid),
      .cmd_pop      (cmd_pop),
      .cmd          (cmd),
      .rsp_full     (eng_full),
      .rsp_push     (eng_push),
      .rsp          (eng_rsp)
   );

   pipw_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (eng_push),
      .full      (eng_full),
      .push_data (eng_rsp),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (out_rsp)
   );

   assign rsp_inside_res = out_rsp.inside_res;
   assign rsp_winding    = out_rsp.winding;

endmodule
`default_nettype wire

// ===== hw/rtl/pipw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pipw_front
// Accepts transactions, classifies them as vertex loads or point tests and
// queues them for the edge engine. Loads to slots beyond the table are dropped.
// ----------------------------------------------------------------------------
module pipw_front
   import pipw_pkg::*;
#(
   parameter int MAX_VERTICES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_kind,
   input  logic [SLOT_W-1:0]         req_vertex_index,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   output logic                      cmd_valid,
   input  logic                      cmd_pop,
   output cmd_type                   cmd
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       accept;
   logic       slot_ok;
   logic       keep;
   logic       pop_fire;

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];

   assign accept   = req_push && !req_full;
   assign slot_ok  = (req_kind == OP_TEST) || (int'(req_vertex_index) < MAX_VERTICES);
   assign keep     = accept && slot_ok;
   assign pop_fire = cmd_pop && cmd_valid;
   assign count_in = count_ff + 2'(keep) - 2'(pop_fire);

   always_ff @(posedge clock) begin
      if (keep) begin
         entry_ff[wr_ptr_ff] <= '{op: req_kind, slot: req_vertex_index,
                                  x: req_coord_x, y: req_coord_y};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (keep) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_fire) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/pipw_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pipw_engine
// Back end: owns the vertex memory, writes loads, and walks the polygon edges
// of a test one per cycle through a diff / abs / multiply / compare pipeline.
// ----------------------------------------------------------------------------
module pipw_engine
   import pipw_pkg::*;
#(
   parameter int MAX_VERTICES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [$clog2(MAX_VERTICES+1)-1:0]     vertex_count,
   input  logic                                  cmd_valid,
   output logic                                  cmd_pop,
   input  cmd_type                               cmd,
   input  logic                                  rsp_full,
   output logic                                  rsp_push,
   output rsp_type                               rsp
);

   localparam int IDX_W   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int EXT_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * COORD_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_RESULT = 2'd3;

   logic [1:0]                state_ff;
   logic [CNT_W-1:0]          rd_cnt_ff;
   logic signed [COORD_W-1:0] px_ff;
   logic signed [COORD_W-1:0] py_ff;
   logic signed [SUM_W-1:0]   sum_ff;

   // vertex memory, x in the upper half
   logic [2*COORD_W-1:0]      vtx_mem [MAX_VERTICES];
   logic [2*COORD_W-1:0]      rd_data_ff;
   logic                      mem_we;
   logic [EXT_W-1:0]          slot_ext;
   logic [IDX_W-1:0]          waddr;
   logic [IDX_W-1:0]          raddr;

   logic                      rd_vld_ff;
   logic                      rd_first_ff;
   logic                      rd_last_ff;
   logic signed [COORD_W-1:0] cur_x;
   logic signed [COORD_W-1:0] cur_y;
   logic signed [COORD_W-1:0] prev_x_ff;
   logic signed [COORD_W-1:0] prev_y_ff;

   // stage 1: differences and crossing direction
   logic                      s1_vld_ff;
   logic                      s1_last_ff;
   logic signed [DIFF_W-1:0]  s1_a_ff;
   logic signed [DIFF_W-1:0]  s1_b_ff;
   logic signed [DIFF_W-1:0]  s1_c_ff;
   logic signed [DIFF_W-1:0]  s1_d_ff;
   logic                      s1_up_ff;
   logic                      s1_dn_ff;

   // stage 2: magnitudes and product signs
   logic                      s2_vld_ff;
   logic                      s2_last_ff;
   logic [COORD_W-1:0]        s2_ma_ff;
   logic [COORD_W-1:0]        s2_mb_ff;
   logic [COORD_W-1:0]        s2_mc_ff;
   logic [COORD_W-1:0]        s2_md_ff;
   logic                      s2_z1_ff;
   logic                      s2_n1_ff;
   logic                      s2_z2_ff;
   logic                      s2_n2_ff;
   logic                      s2_up_ff;
   logic                      s2_dn_ff;

   // stage 3: products
   logic                      s3_vld_ff;
   logic                      s3_last_ff;
   logic [PROD_W-1:0]         s3_m1_ff;
   logic [PROD_W-1:0]         s3_m2_ff;
   logic                      s3_z1_ff;
   logic                      s3_n1_ff;
   logic                      s3_z2_ff;
   logic                      s3_n2_ff;
   logic                      s3_up_ff;
   logic                      s3_dn_ff;

   // stage 4: winding step
   logic                      s4_vld_ff;
   logic                      s4_last_ff;
   logic                      s4_up_ff;
   logic                      s4_dn_ff;

   logic signed [1:0]         sg1;
   logic signed [1:0]         sg2;
   logic signed [1:0]         cross_sg;
   logic                      m_gt;
   logic                      m_lt;
   int                        sum_int;

   function automatic logic [COORD_W-1:0] mag_of(input logic signed [DIFF_W-1:0] v);
      logic signed [DIFF_W-1:0] a;
      a = v[DIFF_W-1] ? -v : v;
      return a[COORD_W-1:0];
   endfunction

   // ---------------------------------------------------------------- control
   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;
   assign mem_we   = cmd_pop && (cmd.op == OP_LOAD);
   assign slot_ext = EXT_W'(cmd.slot);
   assign waddr    = slot_ext[IDX_W-1:0];
   // closing edge re-reads vertex 0
   assign raddr    = (rd_cnt_ff == vertex_count) ? '0 : rd_cnt_ff[IDX_W-1:0];
   assign rsp_push = (state_ff == ST_RESULT) && !rsp_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid && (cmd.op == OP_TEST)) begin
                  state_ff <= (vertex_count == '0) ? ST_RESULT : ST_WALK;
               end
            end
            ST_WALK: begin
               if (rd_cnt_ff == vertex_count) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (s4_vld_ff && s4_last_ff) begin
                  state_ff <= ST_RESULT;
               end
            end
            ST_RESULT: begin
               if (!rsp_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && (cmd.op == OP_TEST)) begin
         px_ff     <= cmd.x;
         py_ff     <= cmd.y;
         rd_cnt_ff <= '0;
      end else if (state_ff == ST_WALK) begin
         rd_cnt_ff <= rd_cnt_ff + CNT_W'(1);
      end
      if (cmd_pop && (cmd.op == OP_TEST)) begin
         sum_ff <= '0;
      end else if (s4_vld_ff) begin
         sum_ff <= sum_ff + SUM_W'(s4_up_ff) - SUM_W'(s4_dn_ff);
      end
   end

   // ----------------------------------------------------------------- memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vtx_mem[waddr] <= {cmd.x, cmd.y};
      end
      rd_data_ff <= vtx_mem[raddr];
   end

   // --------------------------------------------------------- valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff  <= (state_ff == ST_WALK);
         s1_vld_ff  <= rd_vld_ff && !rd_first_ff;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
      end
   end

   // ----------------------------------------------------------- data pipeline
   assign cur_x = rd_data_ff[2*COORD_W-1:COORD_W];
   assign cur_y = rd_data_ff[COORD_W-1:0];

   always_ff @(posedge clock) begin
      rd_first_ff <= (rd_cnt_ff == '0);
      rd_last_ff  <= (rd_cnt_ff == vertex_count);
      if (rd_vld_ff) begin
         prev_x_ff <= cur_x;
         prev_y_ff <= cur_y;
      end

      // edge runs from prev (start) to cur (end)
      s1_last_ff <= rd_last_ff;
      s1_a_ff    <= DIFF_W'(cur_x) - DIFF_W'(prev_x_ff);
      s1_b_ff    <= DIFF_W'(py_ff) - DIFF_W'(prev_y_ff);
      s1_c_ff    <= DIFF_W'(cur_y) - DIFF_W'(prev_y_ff);
      s1_d_ff    <= DIFF_W'(px_ff) - DIFF_W'(prev_x_ff);
      s1_up_ff   <= (cur_y > py_ff) && !(prev_y_ff > py_ff);
      s1_dn_ff   <= (prev_y_ff > py_ff) && !(cur_y > py_ff);

      s2_last_ff <= s1_last_ff;
      s2_ma_ff   <= mag_of(s1_a_ff);
      s2_mb_ff   <= mag_of(s1_b_ff);
      s2_mc_ff   <= mag_of(s1_c_ff);
      s2_md_ff   <= mag_of(s1_d_ff);
      s2_z1_ff   <= (s1_a_ff == '0) || (s1_b_ff == '0);
      s2_n1_ff   <= s1_a_ff[DIFF_W-1] ^ s1_b_ff[DIFF_W-1];
      s2_z2_ff   <= (s1_c_ff == '0) || (s1_d_ff == '0);
      s2_n2_ff   <= s1_c_ff[DIFF_W-1] ^ s1_d_ff[DIFF_W-1];
      s2_up_ff   <= s1_up_ff;
      s2_dn_ff   <= s1_dn_ff;

      s3_last_ff <= s2_last_ff;
      s3_m1_ff   <= PROD_W'(s2_ma_ff) * PROD_W'(s2_mb_ff);
      s3_m2_ff   <= PROD_W'(s2_mc_ff) * PROD_W'(s2_md_ff);
      s3_z1_ff   <= s2_z1_ff;
      s3_n1_ff   <= s2_n1_ff;
      s3_z2_ff   <= s2_z2_ff;
      s3_n2_ff   <= s2_n2_ff;
      s3_up_ff   <= s2_up_ff;
      s3_dn_ff   <= s2_dn_ff;

      s4_last_ff <= s3_last_ff;
      s4_up_ff   <= s3_up_ff && (cross_sg == 2'sd1);
      s4_dn_ff   <= s3_dn_ff && (cross_sg == -2'sd1);
   end

   // sign of m1*s1 - m2*s2, products kept as sign and magnitude
   always_comb begin
      sg1  = s3_z1_ff ? 2'sd0 : (s3_n1_ff ? -2'sd1 : 2'sd1);
      sg2  = s3_z2_ff ? 2'sd0 : (s3_n2_ff ? -2'sd1 : 2'sd1);
      m_gt = (s3_m1_ff > s3_m2_ff);
      m_lt = (s3_m1_ff < s3_m2_ff);
      if (sg1 != sg2) begin
         cross_sg = (sg1 > sg2) ? 2'sd1 : -2'sd1;
      end else if (sg1 == 2'sd0) begin
         cross_sg = 2'sd0;
      end else if (sg1 > 2'sd0) begin
         cross_sg = m_gt ? 2'sd1 : (m_lt ? -2'sd1 : 2'sd0);
      end else begin
         cross_sg = m_gt ? -2'sd1 : (m_lt ? 2'sd1 : 2'sd0);
      end
   end

   // ----------------------------------------------------------------- result
   always_comb begin
      sum_int        = int'(sum_ff);
      rsp.inside_res = (sum_ff != '0);
      if (sum_int > WIND_MAX) begin
         rsp.winding = WIND_W'(WIND_MAX);
      end else if (sum_int < WIND_MIN) begin
         rsp.winding = WIND_W'(WIND_MIN);
      end else begin
         rsp.winding = WIND_W'(sum_int);
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/pipw_rsp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pipw_rsp_queue
// Two-entry result queue; lets the engine finish while the consumer stalls.
// ----------------------------------------------------------------------------
module pipw_rsp_queue
   import pipw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  rsp_type push_data,
   input  logic    pop,
   output logic    empty,
   output rsp_type pop_data
);

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push_fire;
   logic       pop_fire;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign push_fire = push && !full;
   assign pop_fire  = pop && !empty;

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_fire) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_fire) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push_fire) - 2'(pop_fire);
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/pipw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pipw_checker
// Port-level checks of the point-in-polygon block, bound to the top level.
// ----------------------------------------------------------------------------
module pipw_checker
   import pipw_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_push,
   input logic                     req_full,
   input logic                     rsp_empty,
   input logic                     rsp_pop,
   input logic                     rsp_inside_res,
   input logic signed [WIND_W-1:0] rsp_winding
);

   // the response queue comes out of reset empty and the request queue not full
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // inside flag must agree with the winding number
   a_inside_match: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_inside_res == (rsp_winding != '0)))
      else $error("inside flag disagrees with winding");

   // a waiting result is not lost
   a_rsp_kept: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("waiting result dropped");

   // a waiting result holds its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_winding) && $stable(rsp_inside_res))
      else $error("waiting result changed");

   // handshake flags stay known once out of reset
   a_flags_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_push, req_full, rsp_empty, rsp_pop}))
      else $error("handshake flag unknown");

endmodule

bind point_in_polygon_winding pipw_checker u_checker (.*);
`default_nettype wire

// ===== bench/point_in_polygon_winding_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_winding_tb
// Self-checking bench for the winding-number point-in-polygon block. Polygons
// are loaded through the request queue and query points are fired at them.
// Every response is compared with an exact winding sum kept in the bench.
// Both queues stall at random, and the response side holds off once for a
// long stretch so that the block fills up.
// ----------------------------------------------------------------------------
module point_in_polygon_winding_tb
   import pipw_pkg::*;
();

   localparam int MAX_VERT      = 64;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES   = 1500;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;

   typedef enum logic [1:0] {SHAPE_NOISE, SHAPE_GRID, SHAPE_LAPS, SHAPE_EXTREME} shape_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic                      req_kind = OP_LOAD;
   logic [SLOT_W-1:0]         req_vertex_index = '0;
   logic signed [COORD_W-1:0] req_coord_x = '0;
   logic signed [COORD_W-1:0] req_coord_y = '0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic                      rsp_inside_res;
   logic signed [WIND_W-1:0]  rsp_winding;
   logic                      csr_wr_en = 1'b0;
   logic [CFG_W-1:0]          csr_wr_data = '0;

   point_in_polygon_winding #(
      .MAX_VERTICES(MAX_VERT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_kind         (req_kind),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_winding      (rsp_winding),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // bench copy of the polygon and the vertex count
   logic signed [COORD_W-1:0] poly_x [MAX_VERT];
   logic signed [COORD_W-1:0] poly_y [MAX_VERT];
   bit                        slot_loaded [MAX_VERT];
   logic [CFG_W-1:0]          poly_count = CFG_W'(CNT_RESET);
   rsp_type                   wind_expected_q [$];

   int        fail_count  = 0;
   int        items_sent  = 0;
   int        cycle_count = 0;
   int        hold_ask    = 0;
   int        hold_seen   = 0;
   int        pop_stall   = 0;
   bit        send_calm   = 1'b0;
   bit        recv_calm   = 1'b0;
   shape_type cur_shape   = SHAPE_EXTREME;
   int        shape_nv    = 4;
   int        lap_ox, lap_oy, lap_r;

   // exact winding sum; cross products at 72 bits cannot overflow
   function automatic rsp_type winding_of_point(input logic signed [COORD_W-1:0] px,
                                                input logic signed [COORD_W-1:0] py);
      logic signed [71:0] ex_sx, py_sy, ey_sy, px_sx, turn;
      int      n, j, dir, wsum;
      rsp_type r;
      n = (poly_count > MAX_VERT) ? MAX_VERT : int'(poly_count);
      wsum = 0;
      for (int i = 0; i < n; i++) begin
         j = (i + 1 == n) ? 0 : i + 1;
         ex_sx = poly_x[j] - poly_x[i];
         py_sy = py - poly_y[i];
         ey_sy = poly_y[j] - poly_y[i];
         px_sx = px - poly_x[i];
         turn  = ex_sx * py_sy - ey_sy * px_sx;
         dir   = int'(poly_y[j] > py) - int'(poly_y[i] > py);
         // a point on the edge gives zero and is not counted
         if ((dir > 0 && turn > 0) || (dir < 0 && turn < 0)) wsum += dir;
      end
      if (wsum > WIND_MAX) wsum = WIND_MAX;
      if (wsum < WIND_MIN) wsum = WIND_MIN;
      r.inside_res = (wsum != 0);
      r.winding    = WIND_W'(wsum);
      return r;
   endfunction

   task automatic push_item(input logic kind, input logic [SLOT_W-1:0] slot,
                            input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
      if (!send_calm && $urandom_range(0, 9) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_kind         <= kind;
      req_vertex_index <= slot;
      req_coord_x      <= x;
      req_coord_y      <= y;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
      if (kind == OP_LOAD) begin
         poly_x[slot]      = x;
         poly_y[slot]      = y;
         slot_loaded[slot] = 1'b1;
      end else begin
         wind_expected_q = {wind_expected_q, winding_of_point(x, y)};
      end
   endtask

   // no result pending, then let queued loads and the engine settle
   task automatic wait_idle();
      req_push <= 1'b0;
      while (wind_expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_vertex_count(input logic [CFG_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      poly_count   = value;
   endtask

   function automatic int lap_jitter();
      return int'($urandom_range(0, lap_r / 2)) - lap_r / 4;
   endfunction

   function automatic logic signed [COORD_W-1:0] extreme_coord();
      case ($urandom_range(0, 7))
         0:       return C_MIN;
         1:       return C_MAX;
         2:       return 0;
         3:       return -1;
         4:       return 1;
         5:       return C_MIN + 1;
         6:       return C_MAX - 1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [COORD_W-1:0] shape_coord(input shape_type sh,
                                                             input bit y_axis);
      case (sh)
         SHAPE_GRID:    return (int'($urandom_range(0, 16)) - 8) * 32768;
         SHAPE_EXTREME: return extreme_coord();
         SHAPE_LAPS:    return (y_axis ? lap_oy : lap_ox) + lap_jitter();
         default:       return $urandom;
      endcase
   endfunction

   // loads slots 0..nload-1; laps go round a jittered square, once per four slots
   task automatic load_polygon(input shape_type sh, input int nv, input int nload);
      int c, cx, cy;
      bit rev;
      cur_shape = sh;
      shape_nv  = nv;
      lap_r     = 1 << $urandom_range(4, 29);
      lap_r     = lap_r + $urandom_range(0, lap_r - 1);
      lap_ox    = $urandom_range(0, 1 << 29) - (1 << 28);
      lap_oy    = $urandom_range(0, 1 << 29) - (1 << 28);
      rev       = $urandom_range(0, 1);
      for (int k = 0; k < nload; k++) begin
         if (sh == SHAPE_LAPS) begin
            c  = rev ? 3 - (k % 4) : k % 4;
            cx = (c == 1 || c == 2) ? lap_r : -lap_r;
            cy = (c >= 2) ? lap_r : -lap_r;
            push_item(OP_LOAD, SLOT_W'(k), lap_ox + cx + lap_jitter(),
                      lap_oy + cy + lap_jitter());
         end else begin
            push_item(OP_LOAD, SLOT_W'(k), shape_coord(sh, 1'b0), shape_coord(sh, 1'b1));
         end
      end
   endtask

   // query points biased toward vertices, edges and shared y values
   task automatic pick_point(output logic signed [COORD_W-1:0] qx,
                             output logic signed [COORD_W-1:0] qy);
      logic signed [COORD_W:0] sx, sy;
      int i, j;
      i  = $urandom_range(0, shape_nv - 1);
      j  = (i + 1 == shape_nv) ? 0 : i + 1;
      sx = poly_x[i] + poly_x[j];
      sy = poly_y[i] + poly_y[j];
      case ($urandom_range(0, 5))
         0: begin
            qx = poly_x[i];
            qy = poly_y[i];
         end
         1: begin
            qx = sx[COORD_W:1];
            qy = sy[COORD_W:1];
         end
         2: begin
            qx = shape_coord(cur_shape, 1'b0);
            qy = poly_y[i];
         end
         3: begin
            qx = shape_coord(cur_shape, 1'b0);
            qy = shape_coord(cur_shape, 1'b1);
         end
         4: begin
            qx = $urandom;
            qy = $urandom;
         end
         default: begin
            qx = poly_x[i] + int'($urandom_range(0, 6)) - 3;
            qy = poly_y[i] + int'($urandom_range(0, 6)) - 3;
         end
      endcase
   endtask

   task automatic run_phase(input int n, input shape_type sh, input int ntests);
      logic signed [COORD_W-1:0] qx, qy;
      int nv, nload;
      nv = (n < 3) ? 3 : ((n > MAX_VERT) ? MAX_VERT : n);
      write_vertex_count(CFG_W'(n));
      nload = nv;
      // now and then only a prefix of the new polygon lands; never leave a
      // slot in use that was not loaded before
      if ($urandom_range(0, 5) == 0) begin
         nload = $urandom_range(1, nv);
         for (int k = nload; k < nv; k++) begin
            if (!slot_loaded[k]) nload = k + 1;
         end
      end
      load_polygon(sh, nv, nload);
      repeat (ntests) begin
         case ($urandom_range(0, 15))
            0: push_item(OP_LOAD, SLOT_W'($urandom), $urandom, $urandom);
            1: push_item(OP_TEST, SLOT_W'($urandom), $urandom, $urandom);
            default: begin
               pick_point(qx, qy);
               push_item(OP_TEST, SLOT_W'($urandom), qx, qy);
            end
         endcase
      end
   endtask

   // reset count of 4 with the square at the coordinate extremes
   task automatic test_reset_square();
      push_item(OP_LOAD, 6'd0, C_MIN, C_MIN);
      push_item(OP_LOAD, 6'd1, C_MAX, C_MIN);
      push_item(OP_LOAD, 6'd2, C_MAX, C_MAX);
      push_item(OP_LOAD, 6'd3, C_MIN, C_MAX);
      push_item(OP_TEST, '1, 0, 0);
      push_item(OP_TEST, 6'd0, C_MIN, C_MIN);
      push_item(OP_TEST, 6'd0, 0, C_MIN);
      push_item(OP_TEST, 6'd0, C_MAX, 0);
      push_item(OP_TEST, 6'd0, C_MIN, 1);
      push_item(OP_TEST, 6'd0, -1, C_MAX);
      push_item(OP_TEST, 6'd0, C_MAX, C_MAX);
      push_item(OP_TEST, '1, -1, -1);
   endtask

   task automatic test_orientation();
      push_item(OP_LOAD, 6'd0, C_MIN, C_MIN);
      push_item(OP_LOAD, 6'd1, C_MIN, C_MAX);
      push_item(OP_LOAD, 6'd2, C_MAX, C_MAX);
      push_item(OP_LOAD, 6'd3, C_MAX, C_MIN);
      push_item(OP_TEST, 6'd0, 0, 0);
      push_item(OP_TEST, 6'd0, 1, 1);
      push_item(OP_TEST, 6'd0, C_MAX - 1, 0);
   endtask

   task automatic test_small_counts();
      write_vertex_count(CFG_W'(3));
      push_item(OP_TEST, 6'd0, -5, 5);
      push_item(OP_TEST, 6'd0, 5, -5);
      write_vertex_count(CFG_W'(2));
      push_item(OP_TEST, 6'd0, 0, 0);
      write_vertex_count(CFG_W'(1));
      push_item(OP_TEST, 6'd0, 0, 0);
      write_vertex_count(CFG_W'(0));
      push_item(OP_TEST, 6'd0, 0, 0);
   endtask

   // full table, then a count beyond it
   task automatic test_table_extremes();
      logic signed [COORD_W-1:0] qx, qy;
      run_phase(MAX_VERT, SHAPE_LAPS, 20);
      write_vertex_count('1);
      repeat (15) begin
         pick_point(qx, qy);
         push_item(OP_TEST, SLOT_W'($urandom), qx, qy);
      end
   endtask

   task automatic test_backpressure();
      logic signed [COORD_W-1:0] qx, qy;
      send_calm = 1'b1;
      write_vertex_count(CFG_W'(3));
      load_polygon(SHAPE_NOISE, 3, 3);
      hold_ask <= hold_ask + 1;
      repeat (80) begin
         pick_point(qx, qy);
         push_item(OP_TEST, SLOT_W'($urandom), qx, qy);
      end
      wait_idle();
   endtask

   task automatic test_random_phases(input int target);
      int first, n;
      first = items_sent;
      while (items_sent - first < target) begin
         case ($urandom_range(0, 15))
            0:       n = $urandom_range(0, 2);
            1:       n = $urandom_range(MAX_VERT + 1, 127);
            2, 3:    n = $urandom_range(17, MAX_VERT);
            default: n = $urandom_range(3, 16);
         endcase
         send_calm  = ($urandom_range(0, 3) == 0);
         recv_calm <= ($urandom_range(0, 3) == 0);
         run_phase(n, shape_type'($urandom_range(0, 3)), $urandom_range(8, 40));
      end
   endtask

   task automatic test_final_calm();
      send_calm  = 1'b1;
      recv_calm <= 1'b1;
      run_phase(12, SHAPE_LAPS, 60);
      run_phase(5, SHAPE_GRID, 40);
   endtask

   task automatic check_response();
      rsp_type want;
      if (wind_expected_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected transaction: inside %0b winding %0d",
                     rsp_inside_res, rsp_winding);
         return;
      end
      want = wind_expected_q.pop_front();
      if (rsp_inside_res !== want.inside_res || rsp_winding !== want.winding) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch: expected inside %0b winding %0d, got inside %0b winding %0d",
                     want.inside_res, $signed(want.winding), rsp_inside_res, rsp_winding);
      end
   endtask

   // response side: check, then decide the next pop
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) check_response();
      if (hold_ask != hold_seen) begin
         hold_seen = hold_ask;
         pop_stall = HOLD_CYCLES;
      end
      if (pop_stall > 0) begin
         pop_stall--;
         rsp_pop <= 1'b0;
      end else if (!recv_calm && $urandom_range(0, 7) == 0) begin
         pop_stall = $urandom_range(0, 15);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[point_in_polygon_winding] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_square();
      test_orientation();
      test_small_counts();
      test_table_extremes();
      test_backpressure();
      test_random_phases(900);
      test_final_calm();
      wait_idle();
      if (fail_count == 0 && wind_expected_q.size() == 0) begin
         $display("[point_in_polygon_winding] OK");
      end else begin
         $display("[point_in_polygon_winding] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/pipw_pkg.sv
hw/rtl/pipw_front.sv
hw/rtl/pipw_engine.sv
hw/rtl/pipw_rsp_queue.sv
hw/rtl/point_in_polygon_winding.sv
hw/rtl/pipw_checker.sv
bench/point_in_polygon_winding_tb.sv
